[rtl/dks_pkg.sv]
`default_nettype none

package dks_pkg;

  localparam int KEY_BITS    = 64;
  localparam int HALF_BITS   = 28;
  localparam int PC1_BITS    = 56;
  localparam int SUBKEY_BITS = 48;
  localparam int NUM_ROUNDS  = 16;

  localparam logic [3:0] LAST_ROUND = 4'd15;

  typedef logic [HALF_BITS-1:0]   half_t;
  typedef logic [SUBKEY_BITS-1:0] subkey_t;
  typedef logic [3:0]             round_t;

  typedef struct packed {
    half_t c;
    half_t d;
  } halves_t;

  // One means the round rotates by two places, zero by one place.
  localparam logic ROT_TWO [NUM_ROUNDS] = '{
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
  };

  localparam logic [6:0] PC1_TABLE [PC1_BITS] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50,
    7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35,
    7'd27, 7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55,
    7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
    7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21,
    7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [5:0] PC2_TABLE [SUBKEY_BITS] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28, 6'd15, 6'd6,
    6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,  6'd16, 6'd7,
    6'd27, 6'd20, 6'd13, 6'd2,  6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Bit one of the DES numbering is the most significant bit.
  function automatic halves_t pc1(input logic [KEY_BITS-1:0] key);
    logic [PC1_BITS-1:0] r;
    for (int i = 0; i < PC1_BITS; i++) begin
      r[PC1_BITS-1-i] = key[KEY_BITS - int'(PC1_TABLE[i])];
    end
    return halves_t'(r);
  endfunction

  function automatic subkey_t pc2(input halves_t cd);
    logic [PC1_BITS-1:0] v;
    subkey_t r;
    v = cd;
    for (int i = 0; i < SUBKEY_BITS; i++) begin
      r[SUBKEY_BITS-1-i] = v[PC1_BITS - int'(PC2_TABLE[i])];
    end
    return r;
  endfunction

  function automatic half_t rotate_half(input half_t x, input logic two);
    return two ? {x[HALF_BITS-3:0], x[HALF_BITS-1:HALF_BITS-2]}
               : {x[HALF_BITS-2:0], x[HALF_BITS-1]};
  endfunction

endpackage

`default_nettype wire

[rtl/dks_front.sv]
`default_nettype none

module dks_front
  import dks_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output      logic                full,
  input  wire logic [KEY_BITS-1:0] des_key,
  output      logic                q_wr,
  output      halves_t             q_data,
  input  wire logic                q_full
);

  logic    held;
  logic    held_next;
  halves_t held_cd;
  logic    accept;

  assign full   = held && q_full;
  assign accept = push && !full;
  assign q_wr   = held && !q_full;
  assign q_data = held_cd;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (q_wr) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
    if (accept) begin
      held_cd <= pc1(des_key);
    end
  end

endmodule

`default_nettype wire

[rtl/dks_queue.sv]
`default_nettype none

module dks_queue
  import dks_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    wr,
  input  wire halves_t wr_data,
  output      logic    q_full,
  input  wire logic    rd,
  output      halves_t rd_data,
  output      logic    q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  halves_t         slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_wr && !do_rd) begin
      count_next = count + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/dks_back.sv]
`default_nettype none

module dks_back
  import dks_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire halves_t q_data,
  input  wire logic    q_empty,
  output      logic    q_rd,
  output      logic    empty,
  input  wire logic    pop,
  output      subkey_t round_subkey,
  output      round_t  round_index,
  output      logic    last_round
);

  logic    busy;
  logic    busy_next;
  halves_t cd;
  halves_t cd_rot;
  round_t  round;
  logic    out_valid;
  logic    advance;
  logic    finishing;

  assign empty     = !out_valid;
  assign advance   = busy && (!out_valid || pop);
  assign finishing = advance && (round == LAST_ROUND);
  assign q_rd      = !q_empty && (!busy || finishing);

  assign cd_rot.c = rotate_half(cd.c, ROT_TWO[round]);
  assign cd_rot.d = rotate_half(cd.d, ROT_TWO[round]);

  always_comb begin
    busy_next = busy;
    if (q_rd) begin
      busy_next = 1'b1;
    end else if (finishing) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      round     <= '0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (q_rd) begin
        round <= '0;
      end else if (advance) begin
        round <= round + 1'b1;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (q_rd) begin
      cd <= q_data;
    end else if (advance) begin
      cd <= cd_rot;
    end
    if (advance) begin
      round_subkey <= pc2(cd_rot);
      round_index  <= round;
      last_round   <= (round == LAST_ROUND);
    end
  end

`ifndef SYNTH
  a_idle_round_zero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> round == '0)
    else $error("round counter is not zero while the engine is idle");

  a_last_flag_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_round |-> round_index == LAST_ROUND)
    else $error("last round flag without the final round index");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    advance && (round != LAST_ROUND) |=> busy && round == $past(round) + 1'b1)
    else $error("run stopped before its final round");

  a_output_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(round_index))
    else $error("waiting subkey was dropped or changed");
`endif

endmodule

`default_nettype wire

[rtl/des_key_schedule.sv]
// Channel   Direction  Handshake      Payload
// key       in         push / full    des_key[63:0]
// subkey    out        pop / empty    round_subkey[47:0], round_index[3:0], last_round
//
// Each key yields sixteen subkeys, one per cycle from the round engine while a low pop
// does not hold it, so a steady stream of keys is taken as the engine finishes each key.
// A key's first subkey passes the key register, a queue slot, the cd register and the output.
// Reset is synchronous and clears the queue, the engine and the output valid flag.
// A low pop holds the engine once a subkey waits; the key register and the queue keep taking keys.
`default_nettype none

module des_key_schedule
  import dks_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output      logic                full,
  input  wire logic [KEY_BITS-1:0] des_key,
  output      logic                empty,
  input  wire logic                pop,
  output      subkey_t             round_subkey,
  output      round_t              round_index,
  output      logic                last_round
);

  logic    q_wr;
  halves_t q_wr_data;
  logic    q_full;
  logic    q_rd;
  halves_t q_rd_data;
  logic    q_empty;

  dks_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .des_key (des_key),
    .q_wr    (q_wr),
    .q_data  (q_wr_data),
    .q_full  (q_full)
  );

  dks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  dks_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (q_rd_data),
    .q_empty      (q_empty),
    .q_rd         (q_rd),
    .empty        (empty),
    .pop          (pop),
    .round_subkey (round_subkey),
    .round_index  (round_index),
    .last_round   (last_round)
  );

endmodule

`default_nettype wire

[tb/tb_des_key_schedule.sv]
`timescale 1ns / 100ps

module tb_des_key_schedule
  import dks_pkg::*;
();

  localparam int RANDOM_KEYS = 430;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT = 1000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  localparam int KEY_PERM[56] = '{
    57, 49, 41, 33, 25, 17,  9,  1, 58, 50, 42, 34, 26, 18,
    10,  2, 59, 51, 43, 35, 27, 19, 11,  3, 60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15,  7, 62, 54, 46, 38, 30, 22,
    14,  6, 61, 53, 45, 37, 29, 21, 13,  5, 28, 20, 12,  4
  };

  localparam int SUBKEY_PERM[48] = '{
    14, 17, 11, 24,  1,  5,  3, 28, 15,  6, 21, 10,
    23, 19, 12,  4, 26,  8, 16,  7, 27, 20, 13,  2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  localparam int ROUND_SHIFT[16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  typedef struct packed {
    logic [63:0] key;
    logic        fixed;
    subkey_t     subkey;
  } key_row_t;

  typedef struct packed {
    subkey_t subkey;
    round_t  index;
    logic    last;
  } subkey_rec_t;

  localparam int NUM_DIRECTED = 15;

  // A fixed row expects the same subkey on every round.
  localparam key_row_t DIRECTED_KEYS[NUM_DIRECTED] = '{
    '{64'h0000000000000000, 1'b1, 48'h000000000000},
    '{64'hFFFFFFFFFFFFFFFF, 1'b1, 48'hFFFFFFFFFFFF},
    '{64'h0101010101010101, 1'b1, 48'h000000000000},
    '{64'hFEFEFEFEFEFEFEFE, 1'b1, 48'hFFFFFFFFFFFF},
    '{64'h0000000000000001, 1'b1, 48'h000000000000},
    '{64'h1F1F1F1F0E0E0E0E, 1'b0, 48'h0},
    '{64'hE0E0E0E0F1F1F1F1, 1'b0, 48'h0},
    '{64'h01FE01FE01FE01FE, 1'b0, 48'h0},
    '{64'hFE01FE01FE01FE01, 1'b0, 48'h0},
    '{64'hAAAAAAAAAAAAAAAA, 1'b0, 48'h0},
    '{64'h5555555555555555, 1'b0, 48'h0},
    '{64'h8000000000000000, 1'b0, 48'h0},
    '{64'h0000000000000002, 1'b0, 48'h0},
    '{64'h133457799BBCDFF1, 1'b0, 48'h0},
    '{64'h0123456789ABCDEF, 1'b0, 48'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] des_key = 64'h0;
  logic        empty;
  logic        pop = 1'b0;
  subkey_t     round_subkey;
  round_t      round_index;
  logic        last_round;

  subkey_rec_t subkeys_due[$];
  int          mismatches = 0;
  int          subkeys_checked = 0;
  int          cycle_count = 0;

  des_key_schedule dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .des_key      (des_key),
    .empty        (empty),
    .pop          (pop),
    .round_subkey (round_subkey),
    .round_index  (round_index),
    .last_round   (last_round)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic expand_key(input logic [63:0] key, input logic fixed, input subkey_t fixed_sk);
    logic [55:0] permuted;
    logic [55:0] joined;
    logic [27:0] c_half;
    logic [27:0] d_half;
    subkey_t     sk;
    subkey_rec_t rec;
    for (int i = 0; i < 56; i++) begin
      permuted[55-i] = key[64-KEY_PERM[i]];
    end
    c_half = permuted[55:28];
    d_half = permuted[27:0];
    for (int r = 0; r < 16; r++) begin
      for (int s = 0; s < ROUND_SHIFT[r]; s++) begin
        c_half = {c_half[26:0], c_half[27]};
        d_half = {d_half[26:0], d_half[27]};
      end
      joined = {c_half, d_half};
      for (int j = 0; j < 48; j++) begin
        sk[47-j] = joined[56-SUBKEY_PERM[j]];
      end
      rec.subkey = fixed ? fixed_sk : sk;
      rec.index = round_t'(r);
      rec.last = (r == 15);
      subkeys_due = {subkeys_due, rec};
    end
  endtask

  task automatic send_key(input logic [63:0] key, input logic fixed, input subkey_t fixed_sk,
                          input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    des_key <= key;
    do @(posedge clk); while (full);
    expand_key(key, fixed, fixed_sk);
  endtask

  task automatic drain_subkeys();
    push <= 1'b0;
    do @(posedge clk); while (subkeys_due.size() != 0);
  endtask

  function automatic logic [63:0] random_key();
    logic [63:0] key;
    int          pick;
    key = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 6) begin
      key = 64'h1 << $urandom_range(0, 63);
    end else if (pick == 7) begin
      key = ~(64'h1 << $urandom_range(0, 63));
    end else if (pick == 8) begin
      key = DIRECTED_KEYS[$urandom_range(0, NUM_DIRECTED-1)].key
            ^ (64'h1 << 8*$urandom_range(0, 7));
    end else if (pick == 9) begin
      key = {8{key[7:0]}};
    end
    return key;
  endfunction

  initial begin
    int gap;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      gap = (i < 5) ? 0 : $urandom_range(0, 9);
      send_key(DIRECTED_KEYS[i].key, DIRECTED_KEYS[i].fixed, DIRECTED_KEYS[i].subkey, gap);
    end
    drain_subkeys();
    for (int n = 0; n < RANDOM_KEYS; n++) begin
      if (n == RANDOM_KEYS / 2) begin
        drain_subkeys();
      end
      gap = ((n / 60) % 4 == 3) ? 0 : $urandom_range(0, 9);
      send_key(random_key(), 1'b0, 48'h0, gap);
    end
    drain_subkeys();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int          wait_cycles;
    subkey_t     got_subkey;
    round_t      got_index;
    logic        got_last;
    subkey_rec_t want;
    wait (rst == 1'b0);
    forever begin
      if (subkeys_checked == HOLD_AT) begin
        wait_cycles = HOLD_CYCLES;
      end else if ((subkeys_checked / 400) % 3 == 1) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, 9);
      end
      if (wait_cycles > 0) begin
        pop <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got_subkey = round_subkey;
      got_index = round_index;
      got_last = last_round;
      subkeys_checked++;
      if (subkeys_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual subkey %h round %0d last %b",
                 $time, got_subkey, got_index, got_last);
        mismatches++;
      end else begin
        want = subkeys_due.pop_front();
        if (got_subkey !== want.subkey) begin
          $display("%0t: round_subkey expected %h actual %h", $time, want.subkey, got_subkey);
          mismatches++;
        end
        if (got_index !== want.index) begin
          $display("%0t: round_index expected %0d actual %0d", $time, want.index, got_index);
          mismatches++;
        end
        if (got_last !== want.last) begin
          $display("%0t: last_round expected %b actual %b", $time, want.last, got_last);
          mismatches++;
        end
      end
    end
  end

endmodule

[files.f]
rtl/dks_pkg.sv
rtl/dks_front.sv
rtl/dks_queue.sv
rtl/dks_back.sv
rtl/des_key_schedule.sv
tb/tb_des_key_schedule.sv
